// File: design/sbso_pkg.sv
// Package for the segment box set occlusion block: widths, codes and types.
package sbso_pkg;
    localparam int MaxBoxes   = 16;
    localparam int CoordBits  = 24;
    localparam int IdxBits    = (MaxBoxes > 1) ? $clog2(MaxBoxes) : 1;
    localparam int CountBits  = 5;
    localparam int DiffBits   = CoordBits + 1;
    localparam int ProdBits   = 2 * DiffBits;
    localparam int BoxBits    = 6 * CoordBits;
    localparam int InBits     = 2 + 6 * CoordBits;
    localparam int InBytes    = (InBits + 7) / 8;
    localparam int OutBytes   = 1;

    typedef logic signed [CoordBits-1:0] t_coord;
    typedef logic signed [DiffBits-1:0]  t_diff;
    typedef logic signed [ProdBits-1:0]  t_prod;

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_ADD   = 2'd1,
        ACT_QUERY = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;
endpackage

// File: design/sbso_ram.sv
// Generic single-port-write, registered-read RAM.
module sbso_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: design/segment_box_set_occlusion.sv
// Top level: box store in RAM, one-box-at-a-time slab test for segment queries.
//
// Every item gives one result beat. The result of a clear, an add or an unused code is
// offered from the output register after the ST_DONE state. A query visits the stored
// boxes one at a time, and each box costs a read state. Each axis then costs only the
// ST_AX state when the segment is parallel to it. Otherwise it passes through ST_AX,
// ST_MIN, ST_MAX and ST_CHK: slab setup, tmin update, tmax update and the tmin <= tmax
// check. The query stops at the first hit. Query time is set by the single 25x25
// multiplier pair that does all rational compares in sequence. The result waits in an
// output register. The next item is taken the cycle after the result has been delivered,
// so the block takes no new item before the last result is delivered.
module segment_box_set_occlusion (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // action, p_x, p_y, p_z, q_x, q_y, q_z
    input  logic [sbso_pkg::InBytes*8-1:0]    s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // blocked, accepted, box_count[4:0]
    output logic [sbso_pkg::OutBytes*8-1:0]   m_axis_tdata
);
    import sbso_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_READ = 7'b0000010,
        ST_AX   = 7'b0000100,
        ST_MIN  = 7'b0001000,
        ST_MAX  = 7'b0010000,
        ST_CHK  = 7'b0100000,
        ST_DONE = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [CountBits-1:0] r_count, n_count;
    logic [IdxBits-1:0]   r_idx, n_idx;
    logic [1:0]           r_ax, n_ax;
    t_coord r_s [3];
    t_coord r_e [3];
    t_diff  r_tmin_n, n_tmin_n, r_tmin_d, n_tmin_d;
    t_diff  r_tmax_n, n_tmax_n, r_tmax_d, n_tmax_d;
    t_diff  r_lo, n_lo, r_hi, n_hi, r_d, n_d;
    logic   r_blocked, n_blocked, r_accepted, n_accepted;
    logic   r_out_valid;

    logic   ram_we;
    logic [BoxBits-1:0] ram_rdata;
    t_coord box_lo [3];
    t_coord box_hi [3];

    logic  in_fire, out_fire;
    t_coord in_p [3];
    t_coord in_q [3];
    t_action in_act;

    assign s_axis_tready = (r_state == ST_IDLE) && !r_out_valid;
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = r_out_valid && m_axis_tready;
    assign in_act   = t_action'(s_axis_tdata[1:0]);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            in_p[k] = s_axis_tdata[2 + k*CoordBits +: CoordBits];
            in_q[k] = s_axis_tdata[2 + (3+k)*CoordBits +: CoordBits];
            box_lo[k] = ram_rdata[k*CoordBits +: CoordBits];
            box_hi[k] = ram_rdata[(3+k)*CoordBits +: CoordBits];
        end
    end

    assign ram_we = in_fire && (in_act == ACT_ADD) && (r_count < CountBits'(MaxBoxes));

    sbso_ram #(.Width(BoxBits), .Depth(MaxBoxes)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[IdxBits-1:0]),
        .i_wdata (s_axis_tdata[2 +: BoxBits]),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    // One signed cross-product compare: sign of an*bd - bn*ad.
    t_diff  cmp_an, cmp_ad, cmp_bn, cmp_bd;
    t_prod  prod_x, prod_y;
    logic   cmp_gt, cmp_lt;
    assign prod_x = t_prod'(cmp_an) * t_prod'(cmp_bd);
    assign prod_y = t_prod'(cmp_bn) * t_prod'(cmp_ad);
    assign cmp_gt = prod_x > prod_y;
    assign cmp_lt = prod_x < prod_y;

    t_diff ax_d, ax_n1, ax_n2;
    t_coord ax_s, ax_lo, ax_hi;
    always_comb begin
        ax_s  = r_s[r_ax];
        ax_lo = box_lo[r_ax];
        ax_hi = box_hi[r_ax];
        ax_d  = t_diff'(r_e[r_ax]) - t_diff'(ax_s);
        ax_n1 = t_diff'(ax_lo) - t_diff'(ax_s);
        ax_n2 = t_diff'(ax_hi) - t_diff'(ax_s);
        if (ax_d < 0) begin
            ax_d  = -ax_d;
            ax_n1 = -ax_n1;
            ax_n2 = -ax_n2;
        end
    end

    always_comb begin
        n_state = r_state; n_count = r_count; n_idx = r_idx; n_ax = r_ax;
        n_tmin_n = r_tmin_n; n_tmin_d = r_tmin_d; n_tmax_n = r_tmax_n; n_tmax_d = r_tmax_d;
        n_lo = r_lo; n_hi = r_hi; n_d = r_d;
        n_blocked = r_blocked; n_accepted = r_accepted;
        cmp_an = r_lo; cmp_ad = r_d; cmp_bn = r_tmin_n; cmp_bd = r_tmin_d;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_blocked = 1'b0; n_accepted = 1'b1; n_idx = '0;
                    n_state = ST_DONE;
                    case (in_act)
                        ACT_CLEAR: n_count = '0;
                        ACT_ADD: begin
                            if (r_count < CountBits'(MaxBoxes)) n_count = r_count + 1'b1;
                            else n_accepted = 1'b0;
                        end
                        ACT_QUERY: begin
                            if ((in_p[0] != in_q[0] || in_p[1] != in_q[1] ||
                                 in_p[2] != in_q[2]) && r_count != '0) begin
                                n_state = ST_READ;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ: begin
                n_ax = '0;
                n_tmin_n = '0; n_tmin_d = t_diff'(1);
                n_tmax_n = t_diff'(1); n_tmax_d = t_diff'(1);
                n_state = ST_AX;
            end
            ST_AX: begin
                if (ax_d == 0) begin
                    if (ax_s < ax_lo || ax_s > ax_hi) begin
                        n_state = ST_DONE;
                        if (CountBits'(r_idx) + 1'b1 < r_count) begin
                            n_idx = r_idx + 1'b1; n_state = ST_READ;
                        end
                    end else if (r_ax == 2'd2) begin
                        n_blocked = 1'b1; n_state = ST_DONE;
                    end else begin
                        n_ax = r_ax + 1'b1;
                    end
                end else begin
                    n_d  = ax_d;
                    n_lo = (ax_n1 < ax_n2) ? ax_n1 : ax_n2;
                    n_hi = (ax_n1 < ax_n2) ? ax_n2 : ax_n1;
                    n_state = ST_MIN;
                end
            end
            ST_MIN: begin
                cmp_an = r_lo; cmp_ad = r_d; cmp_bn = r_tmin_n; cmp_bd = r_tmin_d;
                if (cmp_gt) begin
                    n_tmin_n = r_lo; n_tmin_d = r_d;
                end
                n_state = ST_MAX;
            end
            ST_MAX: begin
                cmp_an = r_hi; cmp_ad = r_d; cmp_bn = r_tmax_n; cmp_bd = r_tmax_d;
                if (cmp_lt) begin
                    n_tmax_n = r_hi; n_tmax_d = r_d;
                end
                n_state = ST_CHK;
            end
            ST_CHK: begin
                // miss when tmin > tmax
                cmp_an = r_tmin_n; cmp_ad = r_tmin_d; cmp_bn = r_tmax_n; cmp_bd = r_tmax_d;
                if (cmp_gt) begin
                    n_state = ST_DONE;
                    if (CountBits'(r_idx) + 1'b1 < r_count) begin
                        n_idx = r_idx + 1'b1; n_state = ST_READ;
                    end
                end else if (r_ax == 2'd2) begin
                    n_blocked = 1'b1; n_state = ST_DONE;
                end else begin
                    n_ax = r_ax + 1'b1; n_state = ST_AX;
                end
            end
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (r_state == ST_DONE) r_out_valid <= 1'b1;
            else if (out_fire) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx; r_ax <= n_ax;
        r_tmin_n <= n_tmin_n; r_tmin_d <= n_tmin_d;
        r_tmax_n <= n_tmax_n; r_tmax_d <= n_tmax_d;
        r_lo <= n_lo; r_hi <= n_hi; r_d <= n_d;
        r_blocked <= n_blocked; r_accepted <= n_accepted;
        if (in_fire) begin
            for (int k = 0; k < 3; k++) begin
                r_s[k] <= in_p[k];
                r_e[k] <= in_q[k];
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_count, r_accepted, r_blocked};
endmodule
